// File: rtl/lkrc_pkg.sv
// Shared types and codes for the keyed LRU result cache.
// No dependencies; the cell and the top level use it by scoped names.
package lkrc_pkg;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        center_index;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
    logic signed [31:0] coord_d;
    logic signed [31:0] coord_e;
    logic signed [31:0] coord_f;
    logic [31:0]        value_in;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [6:0]  entries_used;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } rsp_t;

  // full key of one entry
  typedef struct packed {
    logic [15:0] center;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic [31:0] c4;
    logic [31:0] c5;
  } key_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic clear;      // drop every entry, reset ranks
    logic promote;    // one cell becomes most recent
    logic tgt_match;  // target is the cell that matched
    logic tgt_fill;   // target is the cell at the fill index
    logic tgt_evict;  // target is the least recent cell
    logic use_limit;  // age only cells younger than the limit
    logic new_key;    // target takes the key and turns valid
    logic write_val;  // target takes the value
  } cell_cmd_t;

endpackage

// File: rtl/lkrc_cell.sv
// One cache entry: key, value, valid bit and recency rank.
// Depends on lkrc_pkg for the key and command types.
module lkrc_cell #(
  parameter int CAPACITY = 64,
  parameter int IDX      = 0,
  parameter int RANK_W   = 6,
  parameter int CNT_W    = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmp_en,
  input  lkrc_pkg::key_t      key,
  input  logic [31:0]         value,
  input  lkrc_pkg::cell_cmd_t cmd,
  input  logic [RANK_W-1:0]   limit,
  input  logic [CNT_W-1:0]    fill_count,
  output logic                match,
  output logic [31:0]         stored_value,
  output logic [RANK_W-1:0]   rank
);

  logic           valid;
  lkrc_pkg::key_t stored_key;
  logic           target;

  // register the key compare
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmp_en) begin
      match <= valid && (stored_key == key);
    end
  end

  // pick this cell as the one to promote
  always_comb begin
    target = (cmd.tgt_match && match) ||
             (cmd.tgt_fill && (fill_count == CNT_W'(IDX))) ||
             (cmd.tgt_evict && valid && (rank == RANK_W'(CAPACITY - 1)));
  end

  // apply the update: clear, promote, or age
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.promote) begin
      if (target) begin
        rank <= '0;
        if (cmd.new_key) begin
          valid <= 1'b1;
        end
      end else if (valid && (!cmd.use_limit || (rank < limit))) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // hold key and value
  always_ff @(posedge clk) begin
    if (cmd.promote && !cmd.clear && target) begin
      if (cmd.new_key) begin
        stored_key <= key;
      end
      if (cmd.write_val) begin
        stored_value <= value;
      end
    end
  end

endmodule

// File: rtl/lru_keyed_result_cache.sv
// Keyed LRU result cache built as a row of entry cells.
// The request is registered, the cell compare is registered in the compare step
// and the response register is loaded in the update step. No new request is
// taken until the sequencer has gone from idle through both steps back to idle.
// A held response stalls the update step until it is taken.
// Reset clears all valid bits, ranks, the fill count and both counters at once.
// Depends on lkrc_pkg and lkrc_cell.
module lru_keyed_result_cache #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lkrc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lkrc_pkg::rsp_t rsp
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  lkrc_pkg::req_t      cur;
  lkrc_pkg::key_t      key;
  lkrc_pkg::cell_cmd_t cmd;
  logic [CNT_W-1:0]    fill_count;
  logic [31:0]         hit_counter;
  logic [31:0]         miss_counter;
  logic [CAPACITY-1:0] match;
  logic [31:0]         cell_value [CAPACITY];
  logic [RANK_W-1:0]   cell_rank  [CAPACITY];
  logic                hit;
  logic [31:0]         hit_value;
  logic [RANK_W-1:0]   hit_rank;
  logic                apply_go;
  logic                full;

  assign req_stall = (state != S_IDLE);
  assign apply_go  = (state == S_APPLY) && (!rsp_valid || !rsp_stall);
  assign full      = (fill_count == CNT_W'(CAPACITY));

  assign key = '{center: cur.center_index, c0: cur.coord_a, c1: cur.coord_b,
                 c2: cur.coord_c, c3: cur.coord_d, c4: cur.coord_e,
                 c5: cur.coord_f};

  // capture the request
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cur <= req;
    end
  end

  // advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (apply_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // gather the match results of the row
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (cell_value[i] & {32{match[i]}});
      hit_rank  = hit_rank  | (cell_rank[i] & {RANK_W{match[i]}});
    end
  end
  assign hit = |match;

  // decode the update command
  always_comb begin
    cmd = '0;
    if (apply_go) begin
      case (cur.operation)
        lkrc_pkg::OP_LOOKUP: begin
          cmd.promote   = hit;
          cmd.tgt_match = 1'b1;
          cmd.use_limit = 1'b1;
        end
        lkrc_pkg::OP_INSERT: begin
          cmd.promote   = 1'b1;
          cmd.write_val = 1'b1;
          if (hit) begin
            cmd.tgt_match = 1'b1;
            cmd.use_limit = 1'b1;
          end else begin
            cmd.new_key   = 1'b1;
            cmd.tgt_fill  = !full;
            cmd.tgt_evict = full;
          end
        end
        lkrc_pkg::OP_CLEAR: cmd.clear = 1'b1;
        default: cmd = '0;
      endcase
    end
  end

  // row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkrc_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (g),
      .RANK_W  (RANK_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmp_en      (state == S_CMP),
      .key         (key),
      .value       (cur.value_in),
      .cmd         (cmd),
      .limit       (hit_rank),
      .fill_count  (fill_count),
      .match       (match[g]),
      .stored_value(cell_value[g]),
      .rank        (cell_rank[g])
    );
  end

  // update occupancy and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (apply_go) begin
      case (cur.operation)
        lkrc_pkg::OP_LOOKUP: begin
          if (hit) hit_counter  <= hit_counter + 32'd1;
          else     miss_counter <= miss_counter + 32'd1;
        end
        lkrc_pkg::OP_INSERT: begin
          if (!hit && !full) fill_count <= fill_count + 1'b1;
        end
        lkrc_pkg::OP_CLEAR: fill_count <= '0;
        default: ;
      endcase
    end
  end

  // load the response register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp.found     <= hit && ((cur.operation == lkrc_pkg::OP_LOOKUP) ||
                               (cur.operation == lkrc_pkg::OP_INSERT));
      rsp.value_out <= (hit && (cur.operation == lkrc_pkg::OP_LOOKUP)) ?
                       hit_value : 32'd0;
      rsp.hit_total  <= hit_counter +
                        32'((cur.operation == lkrc_pkg::OP_LOOKUP) && hit);
      rsp.miss_total <= miss_counter +
                        32'((cur.operation == lkrc_pkg::OP_LOOKUP) && !hit);
      if (cur.operation == lkrc_pkg::OP_CLEAR) begin
        rsp.entries_used <= 7'd0;
      end else if ((cur.operation == lkrc_pkg::OP_INSERT) && !hit && !full) begin
        rsp.entries_used <= 7'(fill_count) + 7'd1;
      end else begin
        rsp.entries_used <= 7'(fill_count);
      end
    end
  end

  // at most one entry matches any key
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match)) else $error("more than one entry matched");

  // occupancy never exceeds the row
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY)) else $error("fill count overflow");

  // a new response appears only from the update step
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_APPLY))
    else $error("response without update step");

  // a compare step always follows a request transfer
  a_cmp_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_CMP))
    else $error("compare step missed");

endmodule

// File: tb/sv/testbench.sv
// Testbench for lru_keyed_result_cache: directed and random lookups, inserts and
// clears, checked against an in-bench LRU cache predictor via a scoreboard class.
// Depends on lkrc_pkg and the RTL top level.
module testbench;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;
  // operation code with no function
  localparam logic [1:0] OP_SPARE = 2'd3;

  // predictor of the cache plus a queue of expected responses
  class cache_scoreboard;
    bit                  used_q[SLOTS];
    lkrc_pkg::key_t      key_q[SLOTS];
    logic [31:0]         dist_q[SLOTS];
    int                  rank_q[SLOTS];
    int                  fill;
    logic [31:0]         hits, misses;
    lkrc_pkg::rsp_t      pending[$];
    int                  errors;

    function void clear_all();
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i] = 0;
        rank_q[i] = 0;
      end
      fill = 0;
      hits = 0;
      misses = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int match_slot(lkrc_pkg::key_t k);
      for (int i = 0; i < SLOTS; i++)
        if (used_q[i] && key_q[i] == k) return i;
      return -1;
    endfunction

    function void make_recent(int s, int limit);
      for (int t = 0; t < SLOTS; t++)
        if (t != s && used_q[t] && rank_q[t] < limit) rank_q[t]++;
      rank_q[s] = 0;
    endfunction

    // note an accepted request and predict its response
    function void note_request(lkrc_pkg::req_t r);
      lkrc_pkg::rsp_t e;
      lkrc_pkg::key_t k;
      int s, tgt, oldest;
      k = {r.center_index, r.coord_a, r.coord_b, r.coord_c, r.coord_d,
           r.coord_e, r.coord_f};
      e = '0;
      if (r.operation == lkrc_pkg::OP_LOOKUP) begin
        s = match_slot(k);
        if (s >= 0) begin
          e.found = 1;
          e.value_out = dist_q[s];
          hits++;
          make_recent(s, rank_q[s]);
        end else begin
          misses++;
        end
      end else if (r.operation == lkrc_pkg::OP_INSERT) begin
        s = match_slot(k);
        if (s >= 0) begin
          e.found = 1;
          dist_q[s] = r.value_in;
          make_recent(s, rank_q[s]);
        end else begin
          tgt = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tgt < 0 && !used_q[i]) tgt = i;
          if (tgt >= 0) begin
            fill++;
            make_recent(tgt, 32'h7fffffff);
            used_q[tgt] = 1;
          end else begin
            oldest = 0;
            tgt = 0;
            for (int i = 0; i < SLOTS; i++)
              if (used_q[i] && rank_q[i] >= oldest) begin
                oldest = rank_q[i];
                tgt = i;
              end
            make_recent(tgt, oldest);
          end
          key_q[tgt] = k;
          dist_q[tgt] = r.value_in;
        end
      end else if (r.operation == lkrc_pkg::OP_CLEAR) begin
        for (int i = 0; i < SLOTS; i++) begin
          used_q[i] = 0;
          rank_q[i] = 0;
        end
        fill = 0;
      end
      e.entries_used = fill[6:0];
      e.hit_total = hits;
      e.miss_total = misses;
      pending.push_back(e);
    endfunction

    // compare one response with the oldest expectation
    function void check_response(lkrc_pkg::rsp_t a);
      lkrc_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("response with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.found !== e.found) begin
        $error("found exp %0h got %0h", e.found, a.found); errors++;
      end
      if (a.value_out !== e.value_out) begin
        $error("value_out exp %0h got %0h", e.value_out, a.value_out); errors++;
      end
      if (a.entries_used !== e.entries_used) begin
        $error("entries_used exp %0d got %0d", e.entries_used, a.entries_used);
        errors++;
      end
      if (a.hit_total !== e.hit_total) begin
        $error("hit_total exp %0h got %0h", e.hit_total, a.hit_total); errors++;
      end
      if (a.miss_total !== e.miss_total) begin
        $error("miss_total exp %0h got %0h", e.miss_total, a.miss_total); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  lkrc_pkg::req_t req;
  lkrc_pkg::rsp_t rsp;
  cache_scoreboard board;
  int cycles;
  bit hold_off_done;
  lkrc_pkg::key_t key_pool[96];

  lru_keyed_result_cache u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // check each response transfer
  always @(posedge clk)
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    rsp_stall = 0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk);
        if (!hold_off_done && cycles > 600) begin
          rsp_stall <= 1;
          repeat (300) @(posedge clk);
          hold_off_done = 1;
        end
        case (mode)
          0: rsp_stall <= 0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= ($urandom_range(0, 1) == 0);
          default: rsp_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic lkrc_pkg::req_t build_req(logic [1:0] op, lkrc_pkg::key_t k,
                                               logic [31:0] v);
    lkrc_pkg::req_t r;
    r.operation = op;
    r.center_index = k.center;
    r.coord_a = k.c0; r.coord_b = k.c1; r.coord_c = k.c2;
    r.coord_d = k.c3; r.coord_e = k.c4; r.coord_f = k.c5;
    r.value_in = v;
    return r;
  endfunction

  // offer one request and hold it until transferred
  task automatic send_req(lkrc_pkg::req_t r);
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
  endtask

  task automatic pause_sender();
    req_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic lkrc_pkg::key_t random_key();
    lkrc_pkg::key_t k;
    k.center = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
    k.c0 = pick_coord(); k.c1 = pick_coord(); k.c2 = pick_coord();
    k.c3 = pick_coord(); k.c4 = pick_coord(); k.c5 = pick_coord();
    return k;
  endfunction

  initial begin
    lkrc_pkg::key_t k, k2;
    logic [1:0] op;
    int burst, pick;
    board = new();
    board.clear_all();
    cycles = 0;
    hold_off_done = 0;
    rst = 1;
    req_valid = 0;
    req = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, each operation, update, unused code, clear
    k = '0;
    send_req(build_req(lkrc_pkg::OP_LOOKUP, k, 32'h0));
    send_req(build_req(lkrc_pkg::OP_INSERT, k, 32'hffffffff));
    send_req(build_req(lkrc_pkg::OP_LOOKUP, k, 32'h0));
    k2 = '1;
    send_req(build_req(lkrc_pkg::OP_INSERT, k2, 32'h12345678));
    send_req(build_req(lkrc_pkg::OP_INSERT, k2, 32'h0));
    send_req(build_req(lkrc_pkg::OP_LOOKUP, k2, 32'h0));
    k2.c3 = 32'h7fffffff;
    send_req(build_req(lkrc_pkg::OP_LOOKUP, k2, 32'h0));
    send_req(build_req(OP_SPARE, k2, 32'hffffffff));
    send_req(build_req(lkrc_pkg::OP_CLEAR, k2, 32'h0));
    send_req(build_req(lkrc_pkg::OP_LOOKUP, k, 32'h0));
    // fill past capacity to force evictions
    for (int i = 0; i < 96; i++) key_pool[i] = random_key();
    for (int i = 0; i < 70; i++)
      send_req(build_req(lkrc_pkg::OP_INSERT, key_pool[i], $urandom));
    send_req(build_req(lkrc_pkg::OP_LOOKUP, key_pool[0], 32'h0));
    send_req(build_req(lkrc_pkg::OP_LOOKUP, key_pool[69], 32'h0));

    // random: mostly keys from a pool so hits, updates and evictions occur
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, n++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 50) ? lkrc_pkg::OP_LOOKUP : (pick < 95) ? lkrc_pkg::OP_INSERT :
             (pick < 98) ? lkrc_pkg::OP_CLEAR : OP_SPARE;
        k = ($urandom_range(0, 9) == 0) ? random_key()
            : key_pool[$urandom_range(0, 95)];
        send_req(build_req(op, k, $urandom));
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    req_valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
